// ----- hdl/lcd_window_and_mono_pixel_stream_defines.svh -----
// ----------------------------------------------------------------------------
// LCD byte stream assertion macros
// Shared concurrent assertion forms for the LCD byte stream checker.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_AND_MONO_PIXEL_STREAM_DEFINES_SVH
`define LCD_WINDOW_AND_MONO_PIXEL_STREAM_DEFINES_SVH

// Condition holds in the same cycle as the trigger
`define LCDWM_ASSERT_SAME(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("LCD byte stream: same-cycle check failed");

// Condition holds in the cycle after the trigger
`define LCDWM_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("LCD byte stream: next-cycle check failed");

`endif

// ----- hdl/lcd_wm_pkg.sv -----
// ----------------------------------------------------------------------------
// lcd_wm_pkg
// Beat types, command codes and LCD opcodes for the LCD byte stream block.
// ----------------------------------------------------------------------------
package lcd_wm_pkg;

    // Input beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  x_start;
        logic [7:0]  y_start;
        logic [8:0]  win_width;
        logic [7:0]  win_height;
        logic [7:0]  fb_byte;
        logic [2:0]  bit_index;
        logic [15:0] rgb_pixel;
    } in_item_t;

    // Output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } out_item_t;

    // Item kinds
    localparam logic [1:0] CMD_WINDOW = 2'd0;
    localparam logic [1:0] CMD_MONO   = 2'd1;
    localparam logic [1:0] CMD_RAW    = 2'd2;
    localparam logic [1:0] CMD_SLEEP  = 2'd3;

    // Controller opcodes
    localparam logic [7:0] OP_COLUMN_ADDR = 8'h2A;
    localparam logic [7:0] OP_PAGE_ADDR   = 8'h2B;
    localparam logic [7:0] OP_MEM_WRITE   = 8'h2C;
    localparam logic [7:0] OP_SLEEP_IN    = 8'h10;

    // Configuration registers
    localparam int unsigned CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;
    localparam logic [15:0] FG_COLOR_RESET = 16'hFFFF;
    localparam logic [15:0] BG_COLOR_RESET = 16'h0000;

    // Byte position within one item
    localparam int unsigned BYTE_IDX_W = 4;
    localparam logic [BYTE_IDX_W-1:0] WIN_LAST_IDX   = 4'd10;
    localparam logic [BYTE_IDX_W-1:0] PIX_LAST_IDX   = 4'd1;
    localparam logic [BYTE_IDX_W-1:0] SLEEP_LAST_IDX = 4'd0;

    // Decoded item as held by the sequencer
    typedef struct packed {
        logic [1:0]            kind;
        logic [8:0]            x_start;
        logic [9:0]            x_end;
        logic [7:0]            y_start;
        logic [8:0]            y_end;
        logic [15:0]           colour;
        logic [BYTE_IDX_W-1:0] last_idx;
        logic                  empty;
    } plan_t;

endpackage

// ----- hdl/lcd_wm_plan.sv -----
// ----------------------------------------------------------------------------
// lcd_wm_plan
// Decodes an input beat: window end points, mono colour pick, byte count.
// ----------------------------------------------------------------------------
module lcd_wm_plan (
    input  lcd_wm_pkg::in_item_t item,
    input  logic [15:0]          fg_color,
    input  logic [15:0]          bg_color,
    output lcd_wm_pkg::plan_t    plan
);
    import lcd_wm_pkg::*;

    logic pix_bit;

    // A bit_index of 0 selects the MSB
    assign pix_bit = item.fb_byte[3'd7 - item.bit_index];

    always_comb begin
        plan.kind    = item.cmd;
        plan.x_start = item.x_start;
        plan.y_start = item.y_start;
        // End point = start + size - 1, wide enough not to wrap for a non-empty window
        plan.x_end   = {1'b0, item.x_start} + {1'b0, item.win_width} - 10'd1;
        plan.y_end   = {1'b0, item.y_start} + {1'b0, item.win_height} - 9'd1;
        plan.colour  = item.rgb_pixel;
        plan.empty   = 1'b0;
        case (item.cmd)
            CMD_WINDOW: begin
                plan.last_idx = WIN_LAST_IDX;
                plan.empty    = (item.win_width == 9'd0) || (item.win_height == 8'd0);
            end
            CMD_MONO: begin
                plan.last_idx = PIX_LAST_IDX;
                plan.colour   = pix_bit ? bg_color : fg_color;
            end
            CMD_RAW: begin
                plan.last_idx = PIX_LAST_IDX;
            end
            default: begin
                plan.last_idx = SLEEP_LAST_IDX;
            end
        endcase
    end

endmodule

// ----- hdl/lcd_wm_seq.sv -----
// ----------------------------------------------------------------------------
// lcd_wm_seq
// Holds one decoded item and walks its bytes into the output register.
// ----------------------------------------------------------------------------
module lcd_wm_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lcd_wm_pkg::plan_t     plan_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lcd_wm_pkg::out_item_t m_data
);
    import lcd_wm_pkg::*;

    // Byte slots of a window item
    localparam logic [BYTE_IDX_W-1:0] SLOT_COL_CMD  = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] SLOT_XS_HI    = 4'd1;
    localparam logic [BYTE_IDX_W-1:0] SLOT_XS_LO    = 4'd2;
    localparam logic [BYTE_IDX_W-1:0] SLOT_XE_HI    = 4'd3;
    localparam logic [BYTE_IDX_W-1:0] SLOT_XE_LO    = 4'd4;
    localparam logic [BYTE_IDX_W-1:0] SLOT_PAGE_CMD = 4'd5;
    localparam logic [BYTE_IDX_W-1:0] SLOT_YS_HI    = 4'd6;
    localparam logic [BYTE_IDX_W-1:0] SLOT_YS_LO    = 4'd7;
    localparam logic [BYTE_IDX_W-1:0] SLOT_YE_HI    = 4'd8;
    localparam logic [BYTE_IDX_W-1:0] SLOT_YE_LO    = 4'd9;
    localparam logic [BYTE_IDX_W-1:0] SLOT_MEM_CMD  = 4'd10;

    logic                  hold_vld_reg;
    plan_t                 plan_reg;
    logic [BYTE_IDX_W-1:0] idx_reg;
    logic                  m_vld_reg;
    out_item_t             m_data_reg;
    out_item_t             m_data_next;

    logic out_free;
    logic step;
    logic step_last;
    logic accept;

    // Handshake: output register free, held item advances one byte
    assign out_free  = !m_vld_reg || m_ready;
    assign step      = hold_vld_reg && out_free;
    assign step_last = step && (idx_reg == plan_reg.last_idx);
    assign s_ready   = !hold_vld_reg || step_last;
    assign accept    = s_valid && s_ready;

    // Byte select for the current slot
    always_comb begin
        m_data_next.last     = (idx_reg == plan_reg.last_idx);
        m_data_next.is_data  = 1'b1;
        m_data_next.out_byte = 8'd0;
        case (plan_reg.kind)
            CMD_WINDOW: begin
                m_data_next.is_data = !(idx_reg inside {SLOT_COL_CMD, SLOT_PAGE_CMD,
                                                        SLOT_MEM_CMD});
                case (idx_reg)
                    SLOT_COL_CMD:  m_data_next.out_byte = OP_COLUMN_ADDR;
                    SLOT_XS_HI:    m_data_next.out_byte = {7'd0, plan_reg.x_start[8]};
                    SLOT_XS_LO:    m_data_next.out_byte = plan_reg.x_start[7:0];
                    SLOT_XE_HI:    m_data_next.out_byte = {6'd0, plan_reg.x_end[9:8]};
                    SLOT_XE_LO:    m_data_next.out_byte = plan_reg.x_end[7:0];
                    SLOT_PAGE_CMD: m_data_next.out_byte = OP_PAGE_ADDR;
                    SLOT_YS_HI:    m_data_next.out_byte = 8'd0;
                    SLOT_YS_LO:    m_data_next.out_byte = plan_reg.y_start;
                    SLOT_YE_HI:    m_data_next.out_byte = {7'd0, plan_reg.y_end[8]};
                    SLOT_YE_LO:    m_data_next.out_byte = plan_reg.y_end[7:0];
                    SLOT_MEM_CMD:  m_data_next.out_byte = OP_MEM_WRITE;
                    default:       m_data_next.out_byte = 8'd0;
                endcase
            end
            CMD_MONO, CMD_RAW: begin
                m_data_next.out_byte = (idx_reg == SLOT_COL_CMD) ? plan_reg.colour[15:8]
                                                                 : plan_reg.colour[7:0];
            end
            default: begin
                m_data_next.is_data  = 1'b0;
                m_data_next.out_byte = OP_SLEEP_IN;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            idx_reg      <= '0;
            m_vld_reg    <= 1'b0;
        end else begin
            if (accept) begin
                // an empty window is taken and dropped
                hold_vld_reg <= !plan_in.empty;
                idx_reg      <= '0;
            end else if (step_last) begin
                hold_vld_reg <= 1'b0;
            end else if (step) begin
                idx_reg <= idx_reg + 4'd1;
            end
            if (out_free) begin
                m_vld_reg <= step;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            plan_reg <= plan_in;
        end
        if (step) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hdl/lcd_window_and_mono_pixel_stream.sv -----
// ----------------------------------------------------------------------------
// lcd_window_and_mono_pixel_stream
// SPI LCD byte stream generator with data/command flag per byte.
// ----------------------------------------------------------------------------
// Each input beat is decoded into an item register and its bytes are then
// sent one per cycle, unless m_ready stalls the output, through a registered
// output: a window beat gives 11 bytes (column, page and memory-write
// commands with the start and end points), a mono or raw pixel beat gives 2
// bytes, a sleep beat gives 1, and a window of zero width or height gives
// none. The next beat is taken in the cycle the current item's last byte is
// loaded into the output register. The user must write the colour registers
// through the cfg port only while the block is idle; the block itself does
// not enforce this.
module lcd_window_and_mono_pixel_stream (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lcd_wm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [15:0]                         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lcd_wm_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lcd_wm_pkg::out_item_t               m_data
);
    import lcd_wm_pkg::*;

    logic [15:0] fg_color_reg;
    logic [15:0] bg_color_reg;
    plan_t       plan;

    // Colour registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg <= FG_COLOR_RESET;
            bg_color_reg <= BG_COLOR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FG_COLOR: fg_color_reg <= cfg_wdata;
                REG_BG_COLOR: bg_color_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    lcd_wm_plan u_plan (
        .item     (s_data),
        .fg_color (fg_color_reg),
        .bg_color (bg_color_reg),
        .plan     (plan)
    );

    lcd_wm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .plan_in (plan),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hdl/lcd_wm_checker.sv -----
// ----------------------------------------------------------------------------
// lcd_wm_checker
// Port-level checks on the LCD byte stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_window_and_mono_pixel_stream_defines.svh"

module lcd_wm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input lcd_wm_pkg::in_item_t                s_data,
    input logic                                m_valid,
    input logic                                m_ready,
    input lcd_wm_pkg::out_item_t               m_data
);
    import lcd_wm_pkg::*;

    logic cmd_beat;
    logic ends_item_op;
    logic cmd_op_ok;

    assign cmd_beat     = m_valid && !m_data.is_data;
    assign ends_item_op = (m_data.out_byte == OP_MEM_WRITE) ||
                          (m_data.out_byte == OP_SLEEP_IN);
    assign cmd_op_ok    = (m_data.out_byte == OP_COLUMN_ADDR) ||
                          (m_data.out_byte == OP_PAGE_ADDR) || ends_item_op;

    // Offered input beat holds until taken
    `LCDWM_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data))

    // Stalled output beat holds
    `LCDWM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Command beats carry only the four opcodes
    `LCDWM_ASSERT_SAME(a_cmd_opcode, aclk, aresetn, cmd_beat, cmd_op_ok)

    // Memory-write and sleep close their item, address commands never do
    `LCDWM_ASSERT_SAME(a_cmd_last, aclk, aresetn, cmd_beat, m_data.last == ends_item_op)

endmodule

bind lcd_window_and_mono_pixel_stream lcd_wm_checker u_lcd_wm_checker (.*);
